// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int FX_W = 17;
  localparam logic [FX_W-1:0] FX_ONE = 17'h10000;

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;

  typedef struct packed {
    logic [16:0] alpha;
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [16:0] brightness;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] alpha_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_word_t;

  typedef struct packed {
    logic [FX_W-1:0] p;
    logic [FX_W-1:0] q;
    logic [FX_W-1:0] t;
  } pqt_t;

  function automatic logic [FX_W-1:0] sat_one(input logic [FX_W-1:0] x);
    sat_one = (x > FX_ONE) ? FX_ONE : x;
  endfunction

  // floor(x * 255 / 65536) as (x << 8) - x
  function automatic logic [7:0] to_byte(input logic [FX_W-1:0] x);
    logic [24:0] prod;
    prod = {x, 8'd0} - 25'(x);
    to_byte = prod[23:16];
  endfunction

endpackage

// ===== design/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to ARGB pixel converter, five register stages, one pixel per clock.
// ----------------------------------------------------------------------------
// Accepts one pixel word every clock (busy is always low) and returns its ARGB
// word through the five register stages as a single-cycle out_valid pulse; the
// receiver must take it then, there is no back pressure. The stages are, in
// order: input scaling and hue split, f*S products, the three V multipliers,
// sector select, and byte scaling.
module hsv_to_rgb_converter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  hsv2rgb_pkg::hsv_word_t  in_pixel,
  output logic                    out_valid,
  output hsv2rgb_pkg::argb_word_t out_pixel
);
  import hsv2rgb_pkg::*;

  logic            accept;
  logic [18:0]     h6;

  // stage 1
  logic            s1_valid_r;
  logic [7:0]      s1_alpha_r, s1_alpha_nxt;
  logic [2:0]      s1_sector_r;
  logic [15:0]     s1_frac_r;
  logic [FX_W-1:0] s1_sat_r, s1_sat_nxt;
  logic [FX_W-1:0] s1_val_r, s1_val_nxt;

  // stages 2..3 side data
  logic            s2_valid_r, s3_valid_r;
  logic [7:0]      s2_alpha_r, s3_alpha_r;
  logic [2:0]      s2_sector_r, s3_sector_r;
  logic            s2_grey_r, s3_grey_r;
  logic [FX_W-1:0] s2_val_r, s3_val_r;
  pqt_t            terms;

  // stage 4
  logic            s4_valid_r;
  logic [7:0]      s4_alpha_r;
  logic [FX_W-1:0] s4_red_r, s4_red_nxt;
  logic [FX_W-1:0] s4_grn_r, s4_grn_nxt;
  logic [FX_W-1:0] s4_blu_r, s4_blu_nxt;

  // stage 5
  logic            out_valid_r;
  argb_word_t      out_pixel_r, out_pixel_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    s1_alpha_nxt = to_byte(sat_one(in_pixel.alpha));
    s1_sat_nxt   = sat_one(in_pixel.saturation);
    s1_val_nxt   = sat_one(in_pixel.brightness);
    h6           = {1'b0, in_pixel.hue, 2'b00} + {2'b00, in_pixel.hue, 1'b0};
  end

  always_ff @(posedge clk) begin
    s1_alpha_r  <= s1_alpha_nxt;
    s1_sector_r <= h6[18:16];
    s1_frac_r   <= h6[15:0];
    s1_sat_r    <= s1_sat_nxt;
    s1_val_r    <= s1_val_nxt;
  end

  hsv2rgb_pqt u_pqt (
    .clk   (clk),
    .frac  (s1_frac_r),
    .sat   (s1_sat_r),
    .val   (s1_val_r),
    .terms (terms)
  );

  always_ff @(posedge clk) begin
    s2_alpha_r  <= s1_alpha_r;
    s2_sector_r <= s1_sector_r;
    s2_grey_r   <= (s1_sat_r == '0);
    s2_val_r    <= s1_val_r;
    s3_alpha_r  <= s2_alpha_r;
    s3_sector_r <= s2_sector_r;
    s3_grey_r   <= s2_grey_r;
    s3_val_r    <= s2_val_r;
  end

  always_comb begin
    if (s3_grey_r) begin
      s4_red_nxt = s3_val_r;
      s4_grn_nxt = s3_val_r;
      s4_blu_nxt = s3_val_r;
    end else begin
      unique case (s3_sector_r)
        SEC_0: begin
          s4_red_nxt = s3_val_r; s4_grn_nxt = terms.t;  s4_blu_nxt = terms.p;
        end
        SEC_1: begin
          s4_red_nxt = terms.q;  s4_grn_nxt = s3_val_r; s4_blu_nxt = terms.p;
        end
        SEC_2: begin
          s4_red_nxt = terms.p;  s4_grn_nxt = s3_val_r; s4_blu_nxt = terms.t;
        end
        SEC_3: begin
          s4_red_nxt = terms.p;  s4_grn_nxt = terms.q;  s4_blu_nxt = s3_val_r;
        end
        SEC_4: begin
          s4_red_nxt = terms.t;  s4_grn_nxt = terms.p;  s4_blu_nxt = s3_val_r;
        end
        default: begin
          s4_red_nxt = s3_val_r; s4_grn_nxt = terms.p;  s4_blu_nxt = terms.q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s4_alpha_r <= s3_alpha_r;
    s4_red_r   <= s4_red_nxt;
    s4_grn_r   <= s4_grn_nxt;
    s4_blu_r   <= s4_blu_nxt;
  end

  always_comb begin
    out_pixel_nxt.alpha_byte = s4_alpha_r;
    out_pixel_nxt.red        = to_byte(s4_red_r);
    out_pixel_nxt.green      = to_byte(s4_grn_r);
    out_pixel_nxt.blue       = to_byte(s4_blu_r);
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

// ===== design/hsv2rgb_pqt.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pqt
// Two-stage datapath forming the p, q and t terms from f, S and V.
// ----------------------------------------------------------------------------
module hsv2rgb_pqt (
  input  logic                   clk,
  input  logic [15:0]            frac,
  input  logic [16:0]            sat,
  input  logic [16:0]            val,
  output hsv2rgb_pkg::pqt_t      terms
);
  import hsv2rgb_pkg::*;

  logic [FX_W-1:0] fs_r, fs_nxt;
  logic [FX_W-1:0] ft_r, ft_nxt;
  logic [FX_W-1:0] ks_r, ks_nxt;
  logic [FX_W-1:0] val_r;
  pqt_t            terms_r, terms_nxt;

  logic [32:0]     prod_fs;
  logic [33:0]     prod_ft;
  logic [FX_W-1:0] kq, kt;
  logic [33:0]     prod_p, prod_q, prod_t;

  // stage A: f*S, (1-f)*S and 1-S
  always_comb begin
    prod_fs = 33'(frac) * 33'(sat);
    prod_ft = 34'(FX_ONE - 17'(frac)) * 34'(sat);
    fs_nxt  = prod_fs[32:16];
    ft_nxt  = prod_ft[32:16];
    ks_nxt  = FX_ONE - sat;
  end

  always_ff @(posedge clk) begin
    fs_r  <= fs_nxt;
    ft_r  <= ft_nxt;
    ks_r  <= ks_nxt;
    val_r <= val;
  end

  // stage B: scale by V
  always_comb begin
    kq          = FX_ONE - fs_r;
    kt          = FX_ONE - ft_r;
    prod_p      = 34'(val_r) * 34'(ks_r);
    prod_q      = 34'(val_r) * 34'(kq);
    prod_t      = 34'(val_r) * 34'(kt);
    terms_nxt.p = prod_p[32:16];
    terms_nxt.q = prod_q[32:16];
    terms_nxt.t = prod_t[32:16];
  end

  always_ff @(posedge clk) begin
    terms_r <= terms_nxt;
  end

  assign terms = terms_r;

endmodule

// ===== design/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input hsv2rgb_pkg::hsv_word_t  in_pixel,
  input logic                    out_valid,
  input hsv2rgb_pkg::argb_word_t out_pixel
);
  import hsv2rgb_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == ($past(start && !busy && rst_n, 5) && $past(rst_n, 4) &&
                  $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)))
    else $error("word lost or invented");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && !busy && in_pixel.saturation == 17'd0, 5) |->
      out_pixel.red == out_pixel.green && out_pixel.green == out_pixel.blue)
    else $error("zero saturation not grey");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && !busy && in_pixel.brightness == 17'd0, 5) |->
      out_pixel.red == 8'd0 && out_pixel.green == 8'd0 && out_pixel.blue == 8'd0)
    else $error("zero value not black");

  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && !busy && in_pixel.alpha >= FX_ONE, 5) |->
      out_pixel.alpha_byte == 8'hFF)
    else $error("full alpha not 255");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
